@@ design/aahrf_pkg.sv @@
//------------------------------------------------------------------------------
// aahrf_pkg
// Shared types and constants for the AAC AU header RTP fragmenter.
//------------------------------------------------------------------------------
`default_nettype none

package aahrf_pkg;

   // configuration register indexes
   localparam logic CSR_MTU_SIZE = 1'b0;
   localparam logic CSR_CYCLE_MS = 1'b1;

   localparam logic [13:0] MTU_RESET   = 14'd1400;
   localparam logic [31:0] CYCLE_RESET = 32'hFFFF_FFFF;
   localparam logic [13:0] MTU_OVERHEAD = 14'd20;

   // result slots of one transaction: four AU header bytes, then the data byte
   localparam logic [2:0] SLOT_HDR0 = 3'd0;
   localparam logic [2:0] SLOT_HDR1 = 3'd1;
   localparam logic [2:0] SLOT_HDR2 = 3'd2;
   localparam logic [2:0] SLOT_HDR3 = 3'd3;
   localparam logic [2:0] SLOT_DATA = 3'd4;

   localparam logic [7:0] AU_HDR_BYTE0 = 8'h00;
   localparam logic [7:0] AU_HDR_BYTE1 = 8'h10;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;     // capture the input transaction
      logic div_start;  // start stamp modulo
      logic load_out;   // load next result into the output register
      logic finish;     // advance frame and fragment positions
   } cmd_type;

   typedef struct packed {
      logic first_byte;   // frame_pos is zero
      logic zero_len;     // incoming frame_length is zero
      logic div_done;     // modulo result ready
      logic out_free;     // output register can take a result
      logic last_result;  // current slot is the data byte
   } sts_type;

endpackage

`default_nettype wire

@@ design/aahrf_divider.sv @@
//------------------------------------------------------------------------------
// aahrf_divider
// Bit-serial restoring remainder unit, one quotient bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none

module aahrf_divider
   import aahrf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      remainder
);

   logic        busy_ff,  busy_in;
   logic        done_ff,  done_in;
   logic [4:0]  cnt_ff,   cnt_in;
   logic [31:0] num_ff,   num_in;
   logic [31:0] den_ff,   den_in;
   logic [31:0] rem_ff,   rem_in;
   logic [32:0] trial;

   // a zero divisor subtracts nothing, so the remainder ends equal to the dividend
   always_comb begin
      trial   = {rem_ff, num_ff[31]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[30:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 32'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[31:0];
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

@@ design/aahrf_datapath.sv @@
//------------------------------------------------------------------------------
// aahrf_datapath
// Frame/fragment counters, latched frame fields, config and output register.
//------------------------------------------------------------------------------
`default_nettype none

module aahrf_datapath
   import aahrf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   input  wire logic        csr_write,
   input  wire logic        csr_addr,
   input  wire logic [31:0] csr_wdata,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [12:0] req_frame_length,
   input  wire logic [31:0] req_frame_stamp,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_packet_end,
   output logic             rsp_marker,
   output logic [31:0]      rsp_wrapped_stamp,
   output logic             rsp_run_last
);

   logic [13:0] mtu_ff;
   logic [31:0] cycle_ff;
   logic [12:0] frame_pos_ff,  frame_pos_in;
   logic [13:0] frag_pos_ff,   frag_pos_in;
   logic [12:0] length_ff;
   logic [31:0] stamp_ff;
   logic [7:0]  byte_ff;
   logic [2:0]  slot_ff,       slot_in;
   logic        valid_ff,      valid_in;
   logic [7:0]  out_byte_ff;
   logic        out_pend_ff;
   logic        out_mark_ff;
   logic [31:0] out_stamp_ff;
   logic        out_last_ff;

   logic        div_done;
   logic [31:0] div_rem;
   logic [13:0] limit;
   logic [12:0] frag_start;
   logic [12:0] remaining;
   logic        mark;
   logic        frame_end;
   logic        pend;
   logic [7:0]  slot_byte;

   aahrf_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (req_frame_stamp),
      .divisor   (cycle_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // per-transaction decisions, from positions before the update
   always_comb begin
      limit      = (mtu_ff <= MTU_OVERHEAD) ? 14'd1 : 14'(mtu_ff - MTU_OVERHEAD);
      frag_start = ({1'b0, frame_pos_ff} >= frag_pos_ff)
                   ? 13'(frame_pos_ff - frag_pos_ff[12:0]) : '0;
      remaining  = 13'(length_ff - frag_start);
      mark       = (length_ff >= frag_start) && ({1'b0, remaining} <= limit);
      frame_end  = (14'({1'b0, frame_pos_ff}) + 14'd1) >= {1'b0, length_ff};
      pend       = frame_end || ((15'({1'b0, frag_pos_ff}) + 15'd1) >= {1'b0, limit});
      unique case (slot_ff)
         SLOT_HDR0: slot_byte = AU_HDR_BYTE0;
         SLOT_HDR1: slot_byte = AU_HDR_BYTE1;
         SLOT_HDR2: slot_byte = length_ff[12:5];
         SLOT_HDR3: slot_byte = {length_ff[4:0], 3'b000};
         default:   slot_byte = byte_ff;
      endcase
   end

   always_comb begin
      frame_pos_in = frame_pos_ff;
      frag_pos_in  = frag_pos_ff;
      slot_in      = slot_ff;
      valid_in     = valid_ff;
      if (cmd.accept) begin
         if (frame_pos_ff == '0) begin
            frag_pos_in = '0;
            slot_in     = SLOT_HDR0;
         end else begin
            slot_in = (frag_pos_ff == '0) ? SLOT_HDR0 : SLOT_DATA;
         end
      end
      if (cmd.load_out) begin
         slot_in = slot_ff + 3'd1;
      end
      if (cmd.finish) begin
         if (frame_end) begin
            frame_pos_in = '0;
            frag_pos_in  = '0;
         end else begin
            frame_pos_in = frame_pos_ff + 13'd1;
            frag_pos_in  = pend ? '0 : frag_pos_ff + 14'd1;
         end
      end
      if (cmd.load_out) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mtu_ff       <= MTU_RESET;
         cycle_ff     <= CYCLE_RESET;
         frame_pos_ff <= '0;
         frag_pos_ff  <= '0;
         length_ff    <= '0;
         stamp_ff     <= '0;
         slot_ff      <= '0;
         valid_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_addr)
               CSR_MTU_SIZE: mtu_ff   <= csr_wdata[13:0];
               CSR_CYCLE_MS: cycle_ff <= csr_wdata;
               default:      ;
            endcase
         end
         frame_pos_ff <= frame_pos_in;
         frag_pos_ff  <= frag_pos_in;
         slot_ff      <= slot_in;
         valid_ff     <= valid_in;
         if (cmd.accept && frame_pos_ff == '0) begin
            length_ff <= req_frame_length;
         end
         if (div_done) begin
            stamp_ff <= div_rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         byte_ff <= req_data_byte;
      end
      if (cmd.load_out) begin
         out_byte_ff  <= slot_byte;
         out_pend_ff  <= (slot_ff == SLOT_DATA) && pend;
         out_mark_ff  <= mark;
         out_stamp_ff <= stamp_ff;
         out_last_ff  <= (slot_ff == SLOT_DATA);
      end
   end

   always_comb begin
      sts.first_byte  = (frame_pos_ff == '0);
      sts.zero_len    = (req_frame_length == '0);
      sts.div_done    = div_done;
      sts.out_free    = !valid_ff || !rsp_stall;
      sts.last_result = (slot_ff == SLOT_DATA);
   end

   assign rsp_valid         = valid_ff;
   assign rsp_payload_byte  = out_byte_ff;
   assign rsp_packet_end    = out_pend_ff;
   assign rsp_marker        = out_mark_ff;
   assign rsp_wrapped_stamp = out_stamp_ff;
   assign rsp_run_last      = out_last_ff;

endmodule

`default_nettype wire

@@ design/aahrf_ctrl.sv @@
//------------------------------------------------------------------------------
// aahrf_ctrl
// Sequencer: take a byte, wrap the stamp on a frame's first byte, emit results.
//------------------------------------------------------------------------------
`default_nettype none

module aahrf_ctrl
   import aahrf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               priority if (sts.first_byte && sts.zero_len) state_in = ST_IDLE;
               else if (sts.first_byte)                     state_in = ST_MOD;
               else                                         state_in = ST_EMIT;
            end
         end
         ST_MOD: begin
            if (sts.div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free && sts.last_result) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            cmd.accept    = req_valid;
            cmd.div_start = req_valid && sts.first_byte && !sts.zero_len;
         end
         ST_MOD: ;
         ST_EMIT: begin
            cmd.load_out = sts.out_free;
            cmd.finish   = sts.out_free && sts.last_result;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ design/aac_au_header_rtp_fragmenter_unit.sv @@
//------------------------------------------------------------------------------
// aac_au_header_rtp_fragmenter_unit
// AAC frame to RTP payload fragmenter with 4-byte AU headers.
//------------------------------------------------------------------------------
// Frames arrive one byte per transaction; frame_length and frame_stamp are
// taken on a frame's first byte (a first byte with length zero is dropped).
// Each fragment carries at most mtu_size-20 data bytes (1 if mtu_size <= 20)
// and opens with the AU header 00 10 len[12:5] {len[4:0],000}. Every result
// carries the stamp modulo cycle_ms (unchanged when cycle_ms is 0), packet_end
// on a fragment's last byte, marker on all bytes of the final fragment, and
// run_last on the last result of a transaction.
// Timing: one byte is in work at a time. A byte inside a fragment is
// accepted and gives one result; a byte that opens a fragment is accepted
// and gives five results. A frame's first byte also waits for the stamp
// modulo, done by a bit-serial remainder unit at one bit per cycle. The output
// register lets the next byte be accepted while the last result still waits.
// Results are held back by rsp_stall. Write csr_* only while idle.
//------------------------------------------------------------------------------
`default_nettype none

module aac_au_header_rtp_fragmenter_unit
   import aahrf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_write,
   input  wire logic        csr_addr,
   input  wire logic [31:0] csr_wdata,
   // input transactions
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [12:0] req_frame_length,
   input  wire logic [31:0] req_frame_stamp,
   // result transactions
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_packet_end,
   output logic             rsp_marker,
   output logic [31:0]      rsp_wrapped_stamp,
   output logic             rsp_run_last
);

   cmd_type cmd;
   sts_type sts;

   aahrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   aahrf_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_write         (csr_write),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .req_data_byte     (req_data_byte),
      .req_frame_length  (req_frame_length),
      .req_frame_stamp   (req_frame_stamp),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_packet_end    (rsp_packet_end),
      .rsp_marker        (rsp_marker),
      .rsp_wrapped_stamp (rsp_wrapped_stamp),
      .rsp_run_last      (rsp_run_last)
   );

   // header bytes never close a packet
   a_hdr_no_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_run_last) |-> !rsp_packet_end)
      else $error("AU header byte flagged as packet end");

   // no input is taken while results of a transaction are being produced
   a_emit_blocks_req: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> req_stall)
      else $error("input accepted during result emission");

   // positions advance only with the data byte of a transaction
   a_finish_on_data: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (cmd.load_out && sts.last_result))
      else $error("position update without data byte");

   // stamp modulo runs only for an accepted first byte
   a_div_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (cmd.accept && sts.first_byte && !sts.zero_len))
      else $error("modulo started without a frame start");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
//------------------------------------------------------------------------------
// tb
// Self-checking bench for the AAC AU header RTP fragmenter.
//------------------------------------------------------------------------------
// Frames go in one byte per transaction. A behavioral model of the
// fragmenter predicts every RTP payload byte: the AU header at each fragment
// start, the packet_end, marker and run_last flags, and the wrapped stamp. The
// model's bytes wait in a queue and are compared field by field with what the
// block returns.
// First comes a short directed table that covers the zero-length drop, the
// small-mtu clamp, the zero cycle pass-through and a register change in the
// middle of a frame. Then three random phases follow, with different idle
// mixes and register settings, and one long receiver hold-off. The run ends
// with part of a maximum-length frame.
//------------------------------------------------------------------------------

module tb;
   import aahrf_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 60;     // covers the stamp modulo
   localparam int PHASE_ITEMS   = 50;
   localparam int HOLD_CYCLES   = 300;

   typedef enum bit {ROW_ITEM, ROW_REGS} row_kind_type;

   // one expected RTP payload byte
   typedef struct packed {
      logic [7:0]  pbyte;
      logic        pend;
      logic        mark;
      logic [31:0] wstamp;
      logic        last;
   } rtp_byte_type;

   // one row of the directed table: either a register pair or a frame byte.
   // Where typed is set, n_out .. wstamp give the expected results by hand.
   typedef struct packed {
      row_kind_type kind;
      logic [13:0] mtu;
      logic [31:0] cyc;
      logic [7:0]  data;
      logic [12:0] len;
      logic [31:0] stamp;
      logic        typed;
      logic [2:0]  n_out;
      logic [7:0]  hdr2;
      logic [7:0]  hdr3;
      logic        pend;
      logic        mark;
      logic [31:0] wstamp;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic        csr_addr;
   logic [31:0] csr_wdata;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic [12:0] req_frame_length;
   logic [31:0] req_frame_stamp;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_packet_end;
   logic        rsp_marker;
   logic [31:0] rsp_wrapped_stamp;
   logic        rsp_run_last;

   // model state: register copies and frame/fragment position
   logic [13:0] cfg_mtu;
   logic [31:0] cfg_cycle;
   logic [12:0] frame_pos;
   logic [13:0] frag_pos;
   logic [12:0] held_len;
   logic [31:0] held_stamp;

   rtp_byte_type payload_due[$];   // bytes predicted but not yet returned

   int mismatches    = 0;
   int cycle_count   = 0;
   int send_idle_pct = 6;
   int rsp_idle_pct  = 88;
   int backlog_hold  = 0;       // cycles the receiver still has to hold off

   // Directed table, walked in order. It starts at the reset settings
   // (mtu 1400, cycle all ones).
   plan_row_type plan [23] = '{
      // zero length on a first byte: dropped, no result
      '{ROW_ITEM, 0, 0, 'h00, 0, 0, 1, 0, 0, 0, 0, 0, 0},
      // one-byte frames; a stamp equal to the cycle wraps to zero
      '{ROW_ITEM, 0, 0, 'hFF, 1, 0, 1, 5, 'h00, 'h08, 1, 1, 0},
      '{ROW_ITEM, 0, 0, 'h00, 1, 32'hFFFF_FFFF, 1, 5, 'h00, 'h08, 1, 1, 0},
      // three-byte frame; length field on later bytes is ignored
      '{ROW_ITEM, 0, 0, 'h5A, 3, 1234, 1, 5, 'h00, 'h18, 0, 1, 1234},
      '{ROW_ITEM, 0, 0, 'hA5, 0, 0, 1, 1, 0, 0, 0, 1, 1234},
      '{ROW_ITEM, 0, 0, 'h3C, 8191, 32'hFFFF_FFFF, 1, 1, 0, 0, 1, 1, 1234},
      // cycle zero: stamp passes through
      '{ROW_REGS, 1400, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, 0, 0, 'h81, 2, 32'hFFFF_FFFF, 1, 5, 'h00, 'h10, 0, 1, 32'hFFFF_FFFF},
      '{ROW_ITEM, 0, 0, 'h7E, 0, 0, 1, 1, 0, 0, 1, 1, 32'hFFFF_FFFF},
      // mtu below 21: one data byte per fragment
      '{ROW_REGS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, 0, 0, 'h11, 3, 5, 1, 5, 'h00, 'h18, 1, 0, 5},
      '{ROW_ITEM, 0, 0, 'h22, 0, 0, 1, 5, 'h00, 'h18, 1, 0, 5},
      '{ROW_ITEM, 0, 0, 'h33, 0, 0, 1, 5, 'h00, 'h18, 1, 1, 5},
      // two data bytes per fragment, stamp modulo 1000
      '{ROW_REGS, 22, 1000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, 0, 0, 'h44, 5, 123456, 1, 5, 'h00, 'h28, 0, 0, 456},
      '{ROW_ITEM, 0, 0, 'h55, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, 0, 0, 'h66, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      // limit shrinks mid-frame, open fragment must close on the next byte
      '{ROW_REGS, 21, 1000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, 0, 0, 'h77, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, 0, 0, 'h88, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      // widest mtu, full cycle
      '{ROW_REGS, 16383, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, 0, 0, 'h99, 2, 32'hFFFF_FFFE, 1, 5, 'h00, 'h10, 0, 1, 32'hFFFF_FFFE},
      '{ROW_ITEM, 0, 0, 'h00, 0, 0, 0, 0, 0, 0, 0, 0, 0}
   };

   aac_au_header_rtp_fragmenter_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_frame_length  (req_frame_length),
      .req_frame_stamp   (req_frame_stamp),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_packet_end    (rsp_packet_end),
      .rsp_marker        (rsp_marker),
      .rsp_wrapped_stamp (rsp_wrapped_stamp),
      .rsp_run_last      (rsp_run_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run guard: a hang anywhere ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   //---------------------------------------------------------------------------
   // Fragmenter model
   //---------------------------------------------------------------------------

   function automatic void push_byte(input logic [7:0] pbyte, input logic pend,
                                     input logic mark, input logic [31:0] wstamp,
                                     input logic last);
      rtp_byte_type e;
      e.pbyte  = pbyte;
      e.pend   = pend;
      e.mark   = mark;
      e.wstamp = wstamp;
      e.last   = last;
      payload_due.push_back(e);
   endfunction

   // Takes one accepted frame byte, queues the payload bytes it produces and
   // returns how many there are.
   function automatic int packetize_byte(input logic [7:0] data,
                                         input logic [12:0] len,
                                         input logic [31:0] stamp);
      int unsigned limit, fp, gp, start, remain;
      logic        mark, fend, pend;
      int          n;
      limit = (cfg_mtu <= MTU_OVERHEAD) ? 1 : cfg_mtu - MTU_OVERHEAD;
      if (frame_pos == 0) begin
         if (len == 0)
            return 0;
         held_len   = len;
         held_stamp = (cfg_cycle != 0) ? stamp % cfg_cycle : stamp;
         frag_pos   = 0;
      end
      fp     = frame_pos;
      gp     = frag_pos;
      start  = (fp >= gp) ? fp - gp : 0;
      remain = held_len - start;
      mark   = remain <= limit;
      fend   = fp + 1 >= held_len;
      pend   = fend || (gp + 1 >= limit);
      n      = 1;
      if (frag_pos == 0) begin
         push_byte(AU_HDR_BYTE0, 1'b0, mark, held_stamp, 1'b0);
         push_byte(AU_HDR_BYTE1, 1'b0, mark, held_stamp, 1'b0);
         push_byte(held_len[12:5], 1'b0, mark, held_stamp, 1'b0);
         push_byte({held_len[4:0], 3'b000}, 1'b0, mark, held_stamp, 1'b0);
         n = 5;
      end
      push_byte(data, pend, mark, held_stamp, 1'b1);
      if (fend) begin
         frame_pos = 0;
         frag_pos  = 0;
      end else begin
         frame_pos = frame_pos + 1'b1;
         frag_pos  = pend ? 14'd0 : frag_pos + 1'b1;
      end
      return n;
   endfunction

   //---------------------------------------------------------------------------
   // Result side: stall generator and checker
   //---------------------------------------------------------------------------

   // Random stall, or a long hold-off when backlog_hold is loaded, so that
   // the block fills up and pushes back on its input.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (backlog_hold != 0) begin
            rsp_stall <= 1'b1;
            backlog_hold--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_payload
      rtp_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (payload_due.size() == 0) begin
            $error("unexpected result: payload_byte %02h", rsp_payload_byte);
            mismatches++;
         end else begin
            want = payload_due.pop_front();
            if (rsp_payload_byte !== want.pbyte) begin
               $error("payload_byte: expected %02h, got %02h", want.pbyte, rsp_payload_byte);
               mismatches++;
            end
            if (rsp_packet_end !== want.pend) begin
               $error("packet_end: expected %0b, got %0b", want.pend, rsp_packet_end);
               mismatches++;
            end
            if (rsp_marker !== want.mark) begin
               $error("marker: expected %0b, got %0b", want.mark, rsp_marker);
               mismatches++;
            end
            if (rsp_wrapped_stamp !== want.wstamp) begin
               $error("wrapped_stamp: expected %08h, got %08h", want.wstamp,
                      rsp_wrapped_stamp);
               mismatches++;
            end
            if (rsp_run_last !== want.last) begin
               $error("run_last: expected %0b, got %0b", want.last, rsp_run_last);
               mismatches++;
            end
         end
      end
   end

   //---------------------------------------------------------------------------
   // Input side
   //---------------------------------------------------------------------------

   // Offers one transaction, waits for it to be taken and runs the model on it.
   // Entered and left right after a rising edge; valid stays high on exit.
   task automatic send_item(input logic [7:0] data, input logic [12:0] len,
                            input logic [31:0] stamp, output int n);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= data;
      req_frame_length <= len;
      req_frame_stamp  <= stamp;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      n = packetize_byte(data, len, stamp);
   endtask

   // Wait until every predicted byte is back and the block has gone quiet;
   // a dropped zero-length byte leaves nothing in the queue to wait on.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (payload_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both registers, back to back; unused upper bits of the mtu word are junk.
   task automatic program_regs(input logic [13:0] mtu, input logic [31:0] cyc);
      logic [31:0] word;
      word        = $urandom;
      word[13:0]  = mtu;
      csr_write  <= 1'b1;
      csr_addr   <= CSR_MTU_SIZE;
      csr_wdata  <= word;
      @(posedge clock);
      cfg_mtu     = mtu;
      csr_addr   <= CSR_CYCLE_MS;
      csr_wdata  <= cyc;
      @(posedge clock);
      cfg_cycle   = cyc;
      csr_write  <= 1'b0;
   endtask

   function automatic logic [13:0] pick_mtu();
      case ($urandom_range(9))
         0:       return 14'd0;
         1:       return 14'd20;
         2:       return 14'd21;
         3:       return 14'd16383;
         4:       return MTU_RESET;
         5:       return $urandom_range(16383);
         default: return $urandom_range(21, 32);   // short fragments
      endcase
   endfunction

   function automatic logic [31:0] pick_cycle();
      case ($urandom_range(7))
         0:       return 32'd0;
         1:       return 32'd1;
         2:       return CYCLE_RESET;
         3:       return $urandom;
         default: return $urandom_range(2, 1000);
      endcase
   endfunction

   function automatic logic [31:0] pick_stamp();
      case ($urandom_range(7))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   //---------------------------------------------------------------------------
   // Main sequence
   //---------------------------------------------------------------------------

   initial begin
      int           n;
      int           items_left;
      int           frame_left;
      int           flen;
      plan_row_type row;

      reset            <= 1'b1;
      csr_write        <= 1'b0;
      csr_addr         <= CSR_MTU_SIZE;
      csr_wdata        <= '0;
      req_valid        <= 1'b0;
      req_data_byte    <= '0;
      req_frame_length <= '0;
      req_frame_stamp  <= '0;
      cfg_mtu           = MTU_RESET;
      cfg_cycle         = CYCLE_RESET;
      frame_pos         = '0;
      frag_pos          = '0;
      held_len          = '0;
      held_stamp        = '0;
      frame_left        = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table; hand-typed rows replace what the model queued.
      foreach (plan[i]) begin
         row = plan[i];
         if (row.kind == ROW_REGS) begin
            drain_results();
            program_regs(row.mtu, row.cyc);
         end else begin
            send_item(row.data, row.len, row.stamp, n);
            if (row.typed) begin
               repeat (n) void'(payload_due.pop_back());
               if (row.n_out == 5) begin
                  push_byte(AU_HDR_BYTE0, 1'b0, row.mark, row.wstamp, 1'b0);
                  push_byte(AU_HDR_BYTE1, 1'b0, row.mark, row.wstamp, 1'b0);
                  push_byte(row.hdr2, 1'b0, row.mark, row.wstamp, 1'b0);
                  push_byte(row.hdr3, 1'b0, row.mark, row.wstamp, 1'b0);
               end
               if (row.n_out != 0)
                  push_byte(row.data, row.pend, row.mark, row.wstamp, 1'b1);
            end
         end
      end

      // Random phases: sender rarely idle / receiver mostly stalled, then the
      // reverse, then full rate. Registers change between segments, often in
      // the middle of a frame.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 88 : 0;
         rsp_idle_pct  = (phase == 0) ? 88 : (phase == 1) ? 6 : 0;
         items_left    = PHASE_ITEMS;
         while (items_left > 0) begin
            drain_results();
            program_regs(pick_mtu(), pick_cycle());
            // full-rate phase opens with a long receiver hold-off
            if (phase == 2 && items_left == PHASE_ITEMS)
               backlog_hold = HOLD_CYCLES;
            repeat ($urandom_range(8, 24)) begin
               if (frame_left == 0) begin
                  if ($urandom_range(9) == 0) begin
                     // zero-length first byte: noise, not counted
                     send_item($urandom_range(255), 13'd0, pick_stamp(), n);
                  end else begin
                     flen = ($urandom_range(9) == 0) ? $urandom_range(17, 48)
                                                     : $urandom_range(1, 16);
                     send_item($urandom_range(255), flen, pick_stamp(), n);
                     frame_left = flen - 1;
                     items_left--;
                  end
               end else begin
                  // length and stamp are don't-care past the first byte
                  send_item($urandom_range(255), $urandom_range(8191), $urandom, n);
                  frame_left--;
                  items_left--;
               end
            end
         end
      end

      // close the open frame, then the head of a maximum-length frame
      while (frame_left > 0) begin
         send_item($urandom_range(255), $urandom_range(8191), $urandom, n);
         frame_left--;
      end
      drain_results();
      program_regs(14'd41, pick_cycle());
      send_item($urandom_range(255), 13'd8191, pick_stamp(), n);
      repeat (40)
         send_item($urandom_range(255), $urandom_range(8191), $urandom, n);

      drain_results();
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
